// ===== design/gamepad_to_pointer_packet_macros.svh =====
// Assertion helpers for the pointer packet encoder.
`ifndef GAMEPAD_TO_POINTER_PACKET_MACROS_SVH
`define GAMEPAD_TO_POINTER_PACKET_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define GTPP_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define GTPP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/gtpp_pkg.sv =====
`default_nettype none

package gtpp_pkg;

    localparam logic [7:0] ID_BYTE      = 8'hCA;
    localparam logic [7:0] NEUTRAL_AXIS = 8'd127;
    localparam logic [7:0] BYTE0_IDLE   = 8'hC0;
    localparam logic [7:0] BYTEX_IDLE   = 8'h80;
    localparam logic [7:0] BYTEX_MASK   = 8'hBF;
    localparam logic [2:0] LEVEL_RESET  = 3'd3;
    localparam logic [2:0] LEVEL_MIN    = 3'd1;
    localparam logic [2:0] LEVEL_MAX    = 3'd5;

    typedef struct packed {
        logic [1:0] hi;
        logic [7:0] lo;
    } axis_t;

    function automatic logic [7:0] far_step(input logic [2:0] lvl);
        logic [7:0] v;
        unique case (lvl)
            3'd1:    v = 8'd130;
            3'd2:    v = 8'd149;
            3'd3:    v = 8'd170;
            3'd4:    v = 8'd202;
            default: v = 8'd254;
        endcase
        return v;
    endfunction

    function automatic logic [7:0] near_step(input logic [2:0] lvl);
        logic [7:0] v;
        unique case (lvl)
            3'd1:    v = 8'd125;
            3'd2:    v = 8'd106;
            3'd3:    v = 8'd85;
            3'd4:    v = 8'd53;
            default: v = 8'd1;
        endcase
        return v;
    endfunction

    // Axis magnitude from the directions, then split into packet bits.
    function automatic axis_t pack_axis(input logic neg, input logic pos,
                                        input logic [2:0] lvl);
        axis_t      a;
        logic [7:0] v;
        logic [7:0] t;
        if (pos)
            v = near_step(lvl);
        else if (neg)
            v = far_step(lvl);
        else
            v = NEUTRAL_AXIS;
        t    = (v ^ 8'h7F) + 8'd1;
        a.lo = BYTEX_IDLE;
        a.hi = 2'b00;
        if (v != NEUTRAL_AXIS)
        begin
            a.lo = (BYTEX_IDLE | t) & BYTEX_MASK;
            if (v < NEUTRAL_AXIS)
                a.hi = {1'b0, t[6]};
            else
                a.hi = {1'b1, t[6]};
        end
        return a;
    endfunction

endpackage

`default_nettype wire

// ===== design/gamepad_to_pointer_packet.sv =====
// Pointer packet encoder for a ten-button game pad.
// Input stream s_axis: one poll word per handshake (id request, pad valid,
// button bits). Output stream m_axis: the serial bytes for the host, the id
// byte 0xCA first on a request, then the three packet bytes when the packet
// must go out; tlast marks the final byte of each poll. A poll may give no
// byte at all.
// Flow: a taken word is registered in the input register, then its bytes are
// loaded into the result register, which drives m_axis_tdata; a poll gives up
// to 4 bytes, and one with none skips the result register. The input register
// takes the next word while the result drains, so polls follow back to back.
// Reset: speed level 3, held flags and previous byte0 cleared, both stages
// empty.
// Stall: when m_axis_tready is low the current byte holds; when the input
// word has bytes and the result register is busy, s_axis_tready drops.
`default_nettype none
`include "gamepad_to_pointer_packet_macros.svh"

module gamepad_to_pointer_packet
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [15:0] s_axis_tdata,  // id_request, pad_valid, buttons[9:0], zero pad
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [7:0]       m_axis_tdata,  // out_byte
    output logic             m_axis_tlast
);

    logic        in_valid_reg;
    logic        req_reg;
    logic        pad_reg;
    logic [9:0]  btn_reg;

    logic [2:0]  speed_level_reg, speed_level_next;
    logic        start_held_reg, start_held_next;
    logic        select_held_reg, select_held_next;
    logic [7:0]  prev_byte0_reg;

    logic [31:0] res_data_reg, res_data_next;
    logic [2:0]  res_left_reg;
    logic [2:0]  n_bytes;

    logic        s_take, m_take, res_free, advance, load;
    logic [2:0]  lvl_up;
    logic [7:0]  b0, b1, b2;
    logic        send;
    gtpp_pkg::axis_t ax_x, ax_y;

    assign m_take   = m_axis_tvalid && m_axis_tready;
    assign res_free = (res_left_reg == 3'd0) || (m_take && res_left_reg == 3'd1);
    assign advance  = in_valid_reg && ((n_bytes == 3'd0) || res_free);
    assign load     = advance && (n_bytes != 3'd0);
    assign s_axis_tready = !in_valid_reg || advance;
    assign s_take   = s_axis_tvalid && s_axis_tready;

    always_comb
    begin
        start_held_next  = start_held_reg;
        select_held_next = select_held_reg;
        lvl_up           = speed_level_reg;
        speed_level_next = speed_level_reg;
        b0 = gtpp_pkg::BYTE0_IDLE;
        b1 = gtpp_pkg::BYTEX_IDLE;
        b2 = gtpp_pkg::BYTEX_IDLE;
        ax_x = '0;
        ax_y = '0;
        if (pad_reg)
        begin
            start_held_next  = btn_reg[8];
            select_held_next = btn_reg[9];
            if (btn_reg[8] && !start_held_reg && speed_level_reg < gtpp_pkg::LEVEL_MAX)
                lvl_up = speed_level_reg + 3'd1;
            speed_level_next = lvl_up;
            if (btn_reg[9] && !select_held_reg && lvl_up > gtpp_pkg::LEVEL_MIN)
                speed_level_next = lvl_up - 3'd1;
            ax_x = gtpp_pkg::pack_axis(btn_reg[0], btn_reg[1], speed_level_next);
            ax_y = gtpp_pkg::pack_axis(btn_reg[2], btn_reg[3], speed_level_next);
            b1 = ax_x.lo;
            b2 = ax_y.lo;
            b0 = {2'b11,
                  btn_reg[4] | btn_reg[6] | btn_reg[7],
                  btn_reg[5] | btn_reg[6] | btn_reg[7],
                  ax_y.hi, ax_x.hi};
        end
        send = (b0 != prev_byte0_reg) || (b1 != gtpp_pkg::BYTEX_IDLE)
            || (b2 != gtpp_pkg::BYTEX_IDLE) || (b0[3:0] != 4'd0);
        n_bytes = {2'b00, req_reg} + (send ? 3'd3 : 3'd0);
        if (req_reg)
            res_data_next = {b2, b1, b0, gtpp_pkg::ID_BYTE};
        else
            res_data_next = {8'h00, b2, b1, b0};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg    <= 1'b0;
            res_left_reg    <= 3'd0;
            speed_level_reg <= gtpp_pkg::LEVEL_RESET;
            start_held_reg  <= 1'b0;
            select_held_reg <= 1'b0;
            prev_byte0_reg  <= 8'h00;
        end
        else
        begin
            if (s_take)
                in_valid_reg <= 1'b1;
            else if (advance)
                in_valid_reg <= 1'b0;
            if (advance)
            begin
                speed_level_reg <= speed_level_next;
                start_held_reg  <= start_held_next;
                select_held_reg <= select_held_next;
                prev_byte0_reg  <= b0;
            end
            if (load)
                res_left_reg <= n_bytes;
            else if (m_take)
                res_left_reg <= res_left_reg - 3'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_take)
        begin
            req_reg <= s_axis_tdata[0];
            pad_reg <= s_axis_tdata[1];
            btn_reg <= s_axis_tdata[11:2];
        end
        if (load)
            res_data_reg <= res_data_next;
        else if (m_take)
            res_data_reg <= {8'h00, res_data_reg[31:8]};
    end

    assign m_axis_tvalid = (res_left_reg != 3'd0);
    assign m_axis_tdata  = res_data_reg[7:0];
    assign m_axis_tlast  = (res_left_reg == 3'd1);

    `GTPP_ASSERT_IMPL(a_level_range, 1'b1, speed_level_reg >= gtpp_pkg::LEVEL_MIN && speed_level_reg <= gtpp_pkg::LEVEL_MAX, "speed level out of range")
    `GTPP_ASSERT_IMPL(a_left_range, 1'b1, res_left_reg <= 3'd4, "byte count out of range")
    `GTPP_ASSERT_NEXT(a_burst_whole, m_take && !m_axis_tlast, m_axis_tvalid, "poll bytes broken up")
    `GTPP_ASSERT_NEXT(a_load_count, load, res_left_reg == $past(n_bytes), "byte count not loaded")

endmodule

`default_nettype wire
